// ===== hw/rtl/rce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_pkg
// shared types and codes of the resampled covariance estimator
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int SAMPLE_W = 32;
  localparam int VALUE_W  = 64;
  localparam int IDX_W    = 3;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 4;

  localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FEW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT = 2'd2;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_LEVELS = 1'b1;

  localparam logic MODE_BOOT = 1'b0;
  localparam logic MODE_JACK = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_MEAN_DIV,
    ST_MEAN_WAIT,
    ST_COV_MR,
    ST_COV_MC,
    ST_MAC_RD,
    ST_MAC_DEV,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/rce_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_store
// sample memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module rce_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/rce_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rce_div #(
  parameter int W  = 76,
  parameter int DV = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DV-1:0] divisor,
  output logic          done,
  output logic [W-1:0]  quot,
  output logic          rem_nz
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [DV-1:0] rem_r, rem_nxt;
  logic [DV-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DV:0]   trial;
  logic          fit;

  always_comb begin
    trial    = {rem_r, dvd_r[W-1]};
    fit      = trial >= {1'b0, dvs_r};
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      q_nxt   = '0;
      rem_nxt = '0;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      q_nxt   = {q_r[W-2:0], fit};
      rem_nxt = fit ? DV'(trial - {1'b0, dvs_r}) : trial[DV-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done   = done_r;
  assign quot   = q_r;
  assign rem_nz = rem_r != '0;

endmodule

// ===== hw/rtl/resampled_covariance_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resampled_covariance_estimator_top
// bootstrap / jackknife covariance matrix of resampled level values
// ----------------------------------------------------------------------------
// usage
//   in_* stream: one Q16.16 sample per transfer, resample by resample, levels
//   in order; in_tlast ends the data set. loading never stalls the input.
//   after tlast the block stops taking input and computes the matrix:
//   per level a summing pass over the resamples and one divide for the
//   mean, then per entry a fetch of the two means, a multiply-accumulate
//   pass over the resamples, one divide and the output, all on a single
//   multiplier and a single bit-serial divider of width W = 66 +
//   clog2(MAX_RESAMPLES+1).
//   out_* stream: level count squared entries row-major, out_tlast on the
//   last; fewer than two resamples give one entry with status 1.
//   each entry is held in the output register until out_tready; the sequencer
//   waits meanwhile. in_tready returns after the final entry transfer.
//   reset clears state, load counters, means, out_tvalid and config (jackknife
//   off, 8 levels); the sample memory has no reset value and needs no clearing.
//   cfg_we writes register cfg_index: 0 resample mode, 1 level count.
// ----------------------------------------------------------------------------
module resampled_covariance_estimator_top
  import rce_pkg::*;
#(
  parameter int MAX_LEVELS    = 8,
  parameter int MAX_RESAMPLES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // sample
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [VALUE_W-1:0]  out_tdata,  // cov_value
  output logic [7:0]          out_tuser,  // row_index[2:0], col_index[5:3], status[7:6]
  output logic                out_tlast,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_LEVELS * MAX_RESAMPLES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW   = $clog2(MAX_RESAMPLES + 1);
  localparam int RAW   = (MAX_RESAMPLES > 1) ? $clog2(MAX_RESAMPLES) : 1;
  localparam int LCW   = $clog2(MAX_LEVELS + 1);
  localparam int LAW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SUM_W = SAMPLE_W + RCW;
  localparam int DEV_W = SAMPLE_W + 1;
  localparam int PRD_W = 2 * DEV_W;
  localparam int ACC_W = PRD_W + RCW;

  function automatic logic [AW-1:0] st_addr(input logic [RAW-1:0] b, input logic [LAW-1:0] l);
    return AW'(int'(b) * MAX_LEVELS + int'(l));
  endfunction

  state_t state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [CFG_W-1:0]  nlev_r, nlev_nxt;
  logic [LCW-1:0]    lc_r, lc_nxt;
  logic [RCW-1:0]    rc_r, rc_nxt;
  logic [RCW-1:0]    n_r, n_nxt;
  logic [RAW-1:0]    b_r, b_nxt;
  logic [LCW-1:0]    row_r, row_nxt;
  logic [LCW-1:0]    col_r, col_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] mean_r [MAX_LEVELS];
  logic signed [SAMPLE_W-1:0] mr_r, mr_nxt, mc_r, mc_nxt;
  logic signed [DEV_W-1:0]    dr_r, dr_nxt, dc_r, dc_nxt;
  logic signed [PRD_W-1:0]    prd_r, prd_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic [ACC_W-1:0]  mag_r, mag_nxt;
  logic              ov_r, ov_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic              end_r, end_nxt;
  logic [IDX_W-1:0]  ri_r, ri_nxt, ci_r, ci_nxt;

  logic [LCW-1:0]    lv;
  logic [LCW-1:0]    lc_a, lc_b;
  logic [RCW-1:0]    rc_a, rc_b;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, ra_addr, rb_addr;
  logic [SAMPLE_W-1:0] rd_a, rd_b;
  logic              mean_we;
  logic signed [SAMPLE_W-1:0] mean_wd, mean_rd;
  logic [LAW-1:0]    mean_sel;
  logic              div_start, div_done, div_rnz;
  logic [ACC_W-1:0]  div_dvd, div_q, fin_mag;
  logic [RCW-1:0]    div_dvs;
  logic              in_xfer, b_last, sat;

  assign lv = (nlev_r == '0) ? LCW'(1) :
              (nlev_r > CFG_W'(MAX_LEVELS)) ? LCW'(MAX_LEVELS) : LCW'(nlev_r);
  assign in_xfer = in_tvalid && in_tready;
  assign b_last  = RCW'(b_r) == n_r - 1'b1;

  always_comb begin
    lc_a = lc_r;
    rc_a = rc_r;
    if (lc_r >= lv) begin
      lc_a = '0;
      if (rc_r < RCW'(MAX_RESAMPLES)) rc_a = rc_r + 1'b1;
    end
    wr_en = in_xfer && (rc_a < RCW'(MAX_RESAMPLES));
    lc_b  = lc_a;
    rc_b  = rc_a;
    if (rc_a < RCW'(MAX_RESAMPLES)) begin
      lc_b = lc_a + 1'b1;
      if (lc_b >= lv) begin
        lc_b = '0;
        rc_b = rc_a + 1'b1;
      end
    end
    wr_addr = st_addr(rc_a[RAW-1:0], lc_a[LAW-1:0]);
  end

  assign ra_addr  = st_addr(b_r, row_r[LAW-1:0]);
  assign rb_addr  = st_addr(b_r, col_r[LAW-1:0]);
  assign mean_sel = (state_r == ST_COV_MR) ? row_r[LAW-1:0] : col_r[LAW-1:0];
  assign mean_rd  = mean_r[mean_sel];

  assign div_start = (state_r == ST_MEAN_DIV) || (state_r == ST_SCALE_GO);
  assign div_dvd   = (state_r == ST_MEAN_DIV) ?
                     ACC_W'(sum_r[SUM_W-1] ? -sum_r : sum_r) :
                     (acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r));
  assign div_dvs   = ((state_r == ST_MEAN_DIV) || (mode_r == MODE_JACK)) ? n_r : n_r - 1'b1;
  assign fin_mag   = (mode_r == MODE_JACK) ? mag_r - div_q - ACC_W'(div_rnz) : div_q;
  assign sat       = neg_r ? (fin_mag > {{(ACC_W-VALUE_W){1'b0}}, 64'h8000_0000_0000_0000})
                           : (fin_mag > {{(ACC_W-VALUE_W){1'b0}}, 64'h7FFF_FFFF_FFFF_FFFF});

  rce_store #(.DEPTH(DEPTH), .AW(AW), .DW(SAMPLE_W)) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (in_tdata),
    .raddr_a (ra_addr),
    .raddr_b (rb_addr),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  rce_div #(.W(ACC_W), .DV(RCW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem_nz   (div_rnz)
  );

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    nlev_nxt  = nlev_r;
    lc_nxt    = lc_r;
    rc_nxt    = rc_r;
    n_nxt     = n_r;
    b_nxt     = b_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    sum_nxt   = sum_r;
    mr_nxt    = mr_r;
    mc_nxt    = mc_r;
    dr_nxt    = dr_r;
    dc_nxt    = dc_r;
    prd_nxt   = prd_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ov_nxt    = ov_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    end_nxt   = end_r;
    ri_nxt    = ri_r;
    ci_nxt    = ci_r;
    mean_we   = 1'b0;
    mean_wd   = sum_r[SUM_W-1] ? -div_q[SAMPLE_W-1:0] : div_q[SAMPLE_W-1:0];
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_nxt = cfg_data[0];
        CFG_LEVELS: nlev_nxt = cfg_data;
        default:    ;
      endcase
    end
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          lc_nxt = lc_b;
          rc_nxt = rc_b;
          if (in_tlast) begin
            lc_nxt  = '0;
            rc_nxt  = '0;
            n_nxt   = rc_b;
            b_nxt   = '0;
            row_nxt = '0;
            col_nxt = '0;
            if (rc_b < RCW'(2)) begin
              ov_nxt    = 1'b1;
              val_nxt   = '0;
              st_nxt    = STAT_FEW;
              end_nxt   = 1'b1;
              ri_nxt    = '0;
              ci_nxt    = '0;
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_SUM_RD;
            end
          end
        end
      end
      ST_SUM_RD: state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: begin
        sum_nxt = (b_r == '0) ? SUM_W'($signed(rd_a)) : sum_r + SUM_W'($signed(rd_a));
        if (b_last) begin
          state_nxt = ST_MEAN_DIV;
        end else begin
          b_nxt     = b_r + 1'b1;
          state_nxt = ST_SUM_RD;
        end
      end
      ST_MEAN_DIV: state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean_we = 1'b1;
          b_nxt   = '0;
          if (row_r == lv - 1'b1) begin
            row_nxt   = '0;
            state_nxt = ST_COV_MR;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = ST_SUM_RD;
          end
        end
      end
      ST_COV_MR: begin
        mr_nxt    = mean_rd;
        state_nxt = ST_COV_MC;
      end
      ST_COV_MC: begin
        mc_nxt    = mean_rd;
        acc_nxt   = '0;
        b_nxt     = '0;
        state_nxt = ST_MAC_RD;
      end
      ST_MAC_RD: state_nxt = ST_MAC_DEV;
      ST_MAC_DEV: begin
        dr_nxt    = DEV_W'($signed(rd_a)) - DEV_W'(mr_r);
        dc_nxt    = DEV_W'($signed(rd_b)) - DEV_W'(mc_r);
        state_nxt = ST_MAC_MUL;
      end
      ST_MAC_MUL: begin
        prd_nxt   = dr_r * dc_r;
        state_nxt = ST_MAC_ACC;
      end
      ST_MAC_ACC: begin
        acc_nxt = acc_r + ACC_W'(prd_r);
        if (b_last) begin
          state_nxt = ST_SCALE_GO;
        end else begin
          b_nxt     = b_r + 1'b1;
          state_nxt = ST_MAC_RD;
        end
      end
      ST_SCALE_GO: begin
        neg_nxt   = acc_r[ACC_W-1];
        mag_nxt   = div_dvd;
        state_nxt = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (div_done) begin
          if (sat) begin
            st_nxt  = STAT_SAT;
            val_nxt = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          end else begin
            st_nxt  = STAT_OK;
            val_nxt = neg_r ? -fin_mag[VALUE_W-1:0] : fin_mag[VALUE_W-1:0];
          end
          ri_nxt    = IDX_W'(row_r);
          ci_nxt    = IDX_W'(col_r);
          end_nxt   = (row_r == lv - 1'b1) && (col_r == lv - 1'b1);
          ov_nxt    = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (end_r) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_COV_MR;
            if (col_r == lv - 1'b1) begin
              col_nxt = '0;
              row_nxt = row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      mode_r  <= MODE_BOOT;
      nlev_r  <= CFG_W'(8);
      lc_r    <= '0;
      rc_r    <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) mean_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      nlev_r  <= nlev_nxt;
      lc_r    <= lc_nxt;
      rc_r    <= rc_nxt;
      ov_r    <= ov_nxt;
      if (mean_we) mean_r[row_r[LAW-1:0]] <= mean_wd;
    end
    n_r   <= n_nxt;
    b_r   <= b_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
    sum_r <= sum_nxt;
    mr_r  <= mr_nxt;
    mc_r  <= mc_nxt;
    dr_r  <= dr_nxt;
    dc_r  <= dc_nxt;
    prd_r <= prd_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    val_r <= val_nxt;
    st_r  <= st_nxt;
    end_r <= end_nxt;
    ri_r  <= ri_nxt;
    ci_r  <= ci_nxt;
  end

  assign in_tready  = state_r == ST_LOAD;
  assign out_tvalid = ov_r;
  assign out_tdata  = val_r;
  assign out_tuser  = {st_r, ci_r, ri_r};
  assign out_tlast  = end_r;

endmodule

// ===== hw/rtl/rce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_checker
// port-level checks of the covariance estimator
// ----------------------------------------------------------------------------
module rce_checker
  import rce_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                in_tlast,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [VALUE_W-1:0]  out_tdata,
  input logic [7:0]          out_tuser,
  input logic                out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result waits");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after end of data set");

  a_few_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[7:6] == STAT_FEW |-> out_tlast && out_tdata == '0
      && out_tuser[5:0] == '0)
    else $error("malformed error result");

endmodule

bind resampled_covariance_estimator_top rce_checker u_rce_checker (.*);
